>>> rtl/core/bdar_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdar_pkg
// Shared codes and item types for the button debounce and auto-repeat core.
// ----------------------------------------------------------------------------
package bdar_pkg;

   // qualifier states
   localparam logic [2:0] ST_RELEASED    = 3'd0;
   localparam logic [2:0] ST_PRESS_DEB   = 3'd1;
   localparam logic [2:0] ST_RELEASE_DEB = 3'd2;
   localparam logic [2:0] ST_FIRST_HOLD  = 3'd3;
   localparam logic [2:0] ST_NEXT_HOLD   = 3'd4;

   // reported events
   localparam logic [1:0] EV_NONE     = 2'd0;
   localparam logic [1:0] EV_PRESSED  = 2'd1;
   localparam logic [1:0] EV_RELEASED = 2'd2;
   localparam logic [1:0] EV_HOLD     = 2'd3;

   // item kinds
   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // register indexes
   localparam logic [1:0] CSR_WATCHED_LINE = 2'd0;
   localparam logic [1:0] CSR_DEBOUNCE     = 2'd1;
   localparam logic [1:0] CSR_FIRST_HOLD   = 2'd2;
   localparam logic [1:0] CSR_NEXT_HOLD    = 2'd3;

   localparam int unsigned CSR_DATA_WIDTH = 16;

   typedef struct packed {
      logic       opcode;
      logic [3:0] event_line;
      logic       pin_level;
   } item_type;

   typedef struct packed {
      logic [1:0] button_event;
      logic [2:0] qualifier_state;
   } result_type;

   typedef struct packed {
      logic [3:0]  watched_line;
      logic [7:0]  debounce_ticks;
      logic [15:0] first_hold_ticks;
      logic [15:0] next_hold_ticks;
   } cfg_type;

endpackage
`default_nettype wire

>>> rtl/core/bdar_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdar_step
// Next-state logic of the qualifier: timer countdown, edge and expiry actions.
// ----------------------------------------------------------------------------
module bdar_step
   import bdar_pkg::*;
#(
   parameter int unsigned TIMER_WIDTH = 16
) (
   input  item_type               item,
   input  cfg_type                cfg,
   input  logic [2:0]             fsm,
   input  logic [TIMER_WIDTH-1:0] remaining,
   input  logic [TIMER_WIDTH-1:0] interval,
   output logic [2:0]             fsm_next,
   output logic [TIMER_WIDTH-1:0] remaining_next,
   output logic [TIMER_WIDTH-1:0] interval_next,
   output result_type             result
);

   logic [TIMER_WIDTH-1:0] debounce_val;
   logic [TIMER_WIDTH-1:0] first_val;
   logic [TIMER_WIDTH-1:0] next_val;
   logic [TIMER_WIDTH-1:0] dec;
   logic [1:0]             ev;
   logic                   pressed;

   assign debounce_val = TIMER_WIDTH'(cfg.debounce_ticks);
   assign first_val    = TIMER_WIDTH'(cfg.first_hold_ticks);
   assign next_val     = TIMER_WIDTH'(cfg.next_hold_ticks);
   assign dec          = remaining - TIMER_WIDTH'(1);
   assign pressed      = item.pin_level;

   always_comb begin
      fsm_next       = fsm;
      remaining_next = remaining;
      interval_next  = interval;
      ev             = EV_NONE;
      if (item.opcode == OP_TICK) begin
         if (interval != '0) begin
            remaining_next = dec;
            if (dec == '0) begin
               // expiry: reload, then settle
               remaining_next = interval;
               unique case (fsm)
                  ST_PRESS_DEB: begin
                     interval_next  = pressed ? first_val : debounce_val;
                     remaining_next = pressed ? first_val : debounce_val;
                     fsm_next       = pressed ? ST_FIRST_HOLD : ST_RELEASE_DEB;
                  end
                  ST_RELEASE_DEB: begin
                     interval_next  = pressed ? debounce_val : '0;
                     remaining_next = pressed ? debounce_val : '0;
                     fsm_next       = pressed ? ST_PRESS_DEB : ST_RELEASED;
                  end
                  ST_FIRST_HOLD: begin
                     interval_next  = pressed ? next_val : '0;
                     remaining_next = pressed ? next_val : '0;
                     fsm_next       = pressed ? ST_NEXT_HOLD : ST_RELEASED;
                     ev             = pressed ? EV_HOLD : EV_NONE;
                  end
                  ST_NEXT_HOLD: begin
                     if (pressed) begin
                        ev = EV_HOLD;
                     end else begin
                        interval_next  = '0;
                        remaining_next = '0;
                        fsm_next       = ST_RELEASED;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end else if (item.event_line == cfg.watched_line) begin
         unique case (fsm)
            ST_RELEASED: begin
               if (pressed) begin
                  interval_next  = debounce_val;
                  remaining_next = debounce_val;
                  fsm_next       = ST_PRESS_DEB;
                  ev             = EV_PRESSED;
               end
            end
            ST_PRESS_DEB, ST_RELEASE_DEB: begin
               interval_next  = debounce_val;
               remaining_next = debounce_val;
            end
            default: begin
               interval_next  = debounce_val;
               remaining_next = debounce_val;
               fsm_next       = pressed ? ST_PRESS_DEB : ST_RELEASE_DEB;
               ev             = pressed ? EV_PRESSED : EV_RELEASED;
            end
         endcase
      end
   end

   assign result.button_event    = ev;
   assign result.qualifier_state = fsm_next;

endmodule
`default_nettype wire

>>> rtl/core/button_debounce_auto_repeat_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// button_debounce_auto_repeat_core
// Button qualifier with debounce countdown and auto-repeat hold reporting.
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  req_     in         edge event or tick with sampled pin level
//  rsp_     out        reported event and state after the item
//  csr_     in         register writes
//
//  one item per cycle while rsp_ does not stall; an item's result reaches rsp_ via
//  the input register, then one pass of state logic into the result register
//  the qualifier state updates in that same pass, so items follow back to back
//  a stalled rsp_ holds the result and the waiting item; req_ stalls then
//  synchronous reset clears the qualifier, timer and valid flags and sets the config registers to defaults
// ----------------------------------------------------------------------------
module button_debounce_auto_repeat_core
   import bdar_pkg::*;
#(
   parameter int unsigned TIMER_WIDTH = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output      logic                      req_tready,
   input  wire logic [7:0]                req_tdata,  // event_line, pin_level, zero fill
   input  wire logic                      req_tuser,  // opcode
   output      logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   output      logic [7:0]                rsp_tdata,  // button_event, qualifier_state, zero fill
   input  wire logic                      csr_we,
   input  wire logic [1:0]                csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   cfg_type                cfg_ff;
   item_type               item_ff;
   logic                   item_valid_ff;
   result_type             result_ff;
   logic                   result_valid_ff;
   logic [2:0]             fsm_ff;
   logic [TIMER_WIDTH-1:0] remaining_ff;
   logic [TIMER_WIDTH-1:0] interval_ff;

   logic [2:0]             fsm_in;
   logic [TIMER_WIDTH-1:0] remaining_in;
   logic [TIMER_WIDTH-1:0] interval_in;
   result_type             result_in;
   logic                   fire;

   assign fire       = item_valid_ff && (!result_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || fire;

   bdar_step #(
      .TIMER_WIDTH(TIMER_WIDTH)
   ) u_step (
      .item          (item_ff),
      .cfg           (cfg_ff),
      .fsm           (fsm_ff),
      .remaining     (remaining_ff),
      .interval      (interval_ff),
      .fsm_next      (fsm_in),
      .remaining_next(remaining_in),
      .interval_next (interval_in),
      .result        (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.watched_line     <= 4'd0;
         cfg_ff.debounce_ticks   <= 8'd20;
         cfg_ff.first_hold_ticks <= 16'd500;
         cfg_ff.next_hold_ticks  <= 16'd100;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WATCHED_LINE: cfg_ff.watched_line     <= csr_wdata[3:0];
            CSR_DEBOUNCE:     cfg_ff.debounce_ticks   <= csr_wdata[7:0];
            CSR_FIRST_HOLD:   cfg_ff.first_hold_ticks <= csr_wdata[15:0];
            CSR_NEXT_HOLD:    cfg_ff.next_hold_ticks  <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff   <= 1'b0;
         result_valid_ff <= 1'b0;
         fsm_ff          <= ST_RELEASED;
         remaining_ff    <= '0;
         interval_ff     <= '0;
      end else begin
         if (req_tready) begin
            item_valid_ff <= req_tvalid;
         end
         if (fire) begin
            result_valid_ff <= 1'b1;
            fsm_ff          <= fsm_in;
            remaining_ff    <= remaining_in;
            interval_ff     <= interval_in;
         end else if (rsp_tready) begin
            result_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.opcode     <= req_tuser;
         item_ff.event_line <= req_tdata[3:0];
         item_ff.pin_level  <= req_tdata[4];
      end
      if (fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = result_valid_ff;
   assign rsp_tdata  = {3'b000, result_ff.qualifier_state, result_ff.button_event};

endmodule
`default_nettype wire
